[hw/rtl/psp_pkg.sv]
package psp_pkg;

   localparam logic [7:0]  PAT_TABLE_ID    = 8'h00;
   localparam logic [7:0]  PRIV_LOW        = 8'h40;
   localparam logic [7:0]  PRIV_HIGH       = 8'hFE;
   localparam logic [7:0]  SYNTAX_MAX_ID   = 8'h02;
   localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
   localparam logic [11:0] MIN_SECTION_LEN = 12'd9;
   localparam logic [12:0] POS_LIMIT       = 13'd8191;
   localparam logic [11:0] LEN_RESET       = 12'd1021;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      ST_OK,
      ST_POINTER,
      ST_PRIVATE,
      ST_TRUNCATED,
      ST_SYNTAX,
      ST_TOO_LONG,
      ST_TABLE_ID,
      ST_TOO_SHORT,
      ST_CRC
   } psp_status_type;

   typedef struct packed {
      logic           kind;
      logic [15:0]    prog_num;
      logic [12:0]    map_pid;
      logic [15:0]    ts_ident;
      logic [4:0]     version;
      logic           current_next;
      logic [7:0]     section_index;
      logic [7:0]     final_section_index;
      logic [9:0]     entry_count;
      psp_status_type status;
      logic           last;
   } psp_rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

[hw/rtl/pat_section_parser.sv]
// channel | ports                                   | direction
// req     | req_valid, req_stall, req_data_byte ... | in, one payload byte a beat
// rsp     | rsp_valid, rsp_stall, rsp_kind ...      | out, entry or summary a beat
// csr     | csr_wr_en, csr_wr_data                  | in, max section length
//
// One byte a cycle while req_stall is low; each byte updates the section state
// in the cycle it is taken. Results go into a 4-entry output queue; a byte that
// ends an entry and the buffer pushes two beats, else at most one.
// req_stall rises while fewer than two queue slots are free.
// Reset is synchronous: queue empty, next byte taken as a pointer field.
module pat_section_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [15:0]            rsp_prog_num,
   output logic [12:0]            rsp_map_pid,
   output logic [15:0]            rsp_ts_ident,
   output logic [4:0]             rsp_version,
   output logic                   rsp_current_next,
   output logic [7:0]             rsp_section_index,
   output logic [7:0]             rsp_final_section_index,
   output logic [9:0]             rsp_entry_count,
   output logic [3:0]             rsp_status,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [11:0]            csr_wr_data
);
   import psp_pkg::*;

   logic [11:0]          max_len_ff;
   logic [12:0]          pos_ff, pos_in;
   logic [7:0]           skip_ff, skip_in;
   logic [7:0][7:0]      hdr_ff, hdr_in;
   logic [11:0]          len_ff, len_in;
   logic [31:0]          crc_ff, crc_in;
   logic [31:0]          crcf_ff, crcf_in;
   logic [31:0]          shift_ff, shift_in;
   psp_status_type       err_ff, err_in;

   psp_rsp_type          fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff;

   logic                 accept, pop;
   logic [12:0]          idx, k, avail, crc_at;
   logic [11:0]          len_cur;
   logic [9:0]           ent_cnt, sum_cnt;
   logic                 hdr_ok, emit_entry;
   psp_status_type       sum_status;
   psp_rsp_type          entry_rsp, sum_rsp;

   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (cnt_ff > CNT_W'(FIFO_DEPTH - 2));

   assign hdr_ok = (err_ff == ST_OK) && (hdr_ff[0] == PAT_TABLE_ID) && hdr_ff[1][7]
                   && (len_ff <= max_len_ff) && (len_ff >= MIN_SECTION_LEN);

   always_comb begin
      idx        = req_first_byte ? '0 : pos_ff;
      k          = idx - 13'd1 - {5'd0, skip_ff};
      skip_in    = skip_ff;
      hdr_in     = hdr_ff;
      len_in     = len_ff;
      crc_in     = crc_ff;
      crcf_in    = crcf_ff;
      shift_in   = shift_ff;
      err_in     = err_ff;
      emit_entry = 1'b0;
      len_cur    = (k == 13'd2) ? {hdr_ff[1][3:0], req_data_byte} : len_ff;
      ent_cnt    = 10'((len_cur - MIN_SECTION_LEN) >> 2);
      crc_at     = 13'd8 + {1'b0, ent_cnt, 2'b00};
      if (idx == '0) begin
         skip_in  = req_data_byte;
         hdr_in   = '0;
         len_in   = '0;
         crc_in   = '1;
         crcf_in  = '0;
         shift_in = '0;
         err_in   = ST_OK;
      end else if (idx > {5'd0, skip_ff}) begin
         if (k < 13'd3 || k < {1'b0, len_ff} + 13'd3) begin
            if (k < 13'd8) begin
               hdr_in[k[2:0]] = req_data_byte;
            end
            if (k == 13'd1 && req_data_byte[6] && err_ff == ST_OK
                && !(hdr_ff[0] inside {[PRIV_LOW:PRIV_HIGH]})) begin
               err_in = ST_PRIVATE;
            end
            len_in = len_cur;
            if (k < 13'd3 || k + 13'd1 < {1'b0, len_cur}) begin
               crc_in = crc_byte(crc_ff, req_data_byte);
            end
            shift_in = {shift_ff[23:0], req_data_byte};
            if (k >= 13'd8 && len_cur >= MIN_SECTION_LEN) begin
               if (k >= crc_at && k < crc_at + 13'd4) begin
                  crcf_in = {crcf_ff[23:0], req_data_byte};
               end
               emit_entry = (k >= 13'd11) && (k[1:0] == 2'b11)
                            && (k < crc_at + 13'd3) && hdr_ok;
            end
         end
      end
   end

   always_comb begin
      avail   = idx - {5'd0, skip_in};
      sum_cnt = (len_in >= MIN_SECTION_LEN) ? 10'((len_in - MIN_SECTION_LEN) >> 2) : '0;
      if ({5'd0, skip_in} > idx) begin
         sum_status = ST_POINTER;
      end else if (err_in != ST_OK) begin
         sum_status = err_in;
      end else if (avail < 13'd3 || {1'b0, len_in} + 13'd3 > avail) begin
         sum_status = ST_TRUNCATED;
      end else if (hdr_in[0] <= SYNTAX_MAX_ID && !hdr_in[1][7]) begin
         sum_status = ST_SYNTAX;
      end else if (hdr_in[0] <= SYNTAX_MAX_ID && len_in > max_len_ff) begin
         sum_status = ST_TOO_LONG;
      end else if (hdr_in[0] != PAT_TABLE_ID) begin
         sum_status = ST_TABLE_ID;
      end else if (len_in < MIN_SECTION_LEN) begin
         sum_status = ST_TOO_SHORT;
      end else if (crc_in != crcf_in) begin
         sum_status = ST_CRC;
      end else begin
         sum_status = ST_OK;
      end
   end

   always_comb begin
      entry_rsp                = '0;
      entry_rsp.kind           = KIND_ENTRY;
      entry_rsp.prog_num       = shift_in[31:16];
      entry_rsp.map_pid        = shift_in[12:0];
      entry_rsp.status         = ST_OK;
      entry_rsp.last           = !req_last_byte;

      sum_rsp                     = '0;
      sum_rsp.kind                = KIND_SUMMARY;
      sum_rsp.ts_ident            = {hdr_in[3], hdr_in[4]};
      sum_rsp.version             = hdr_in[5][5:1];
      sum_rsp.current_next        = hdr_in[5][0];
      sum_rsp.section_index       = hdr_in[6];
      sum_rsp.final_section_index = hdr_in[7];
      sum_rsp.entry_count         = sum_cnt;
      sum_rsp.status              = sum_status;
      sum_rsp.last                = 1'b1;

      pos_in = req_last_byte ? '0 : ((idx < POS_LIMIT) ? idx + 13'd1 : POS_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= LEN_RESET;
         pos_ff     <= '0;
         err_ff     <= ST_OK;
         skip_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (accept) begin
            pos_ff  <= pos_in;
            err_ff  <= err_in;
            skip_ff <= skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff   <= hdr_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         crcf_ff  <= crcf_in;
         shift_ff <= shift_in;
         if (emit_entry) begin
            fifo_ff[wr_ptr_ff] <= entry_rsp;
            if (req_last_byte) begin
               fifo_ff[wr_ptr_ff + PTR_W'(1)] <= sum_rsp;
            end
         end else if (req_last_byte) begin
            fifo_ff[wr_ptr_ff] <= sum_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + (accept ? PTR_W'(emit_entry) + PTR_W'(req_last_byte) : '0);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         cnt_ff    <= cnt_ff + (accept ? CNT_W'(emit_entry) + CNT_W'(req_last_byte) : '0)
                      - CNT_W'(pop);
      end
   end

   assign rsp_kind                = fifo_ff[rd_ptr_ff].kind;
   assign rsp_prog_num            = fifo_ff[rd_ptr_ff].prog_num;
   assign rsp_map_pid             = fifo_ff[rd_ptr_ff].map_pid;
   assign rsp_ts_ident            = fifo_ff[rd_ptr_ff].ts_ident;
   assign rsp_version             = fifo_ff[rd_ptr_ff].version;
   assign rsp_current_next        = fifo_ff[rd_ptr_ff].current_next;
   assign rsp_section_index       = fifo_ff[rd_ptr_ff].section_index;
   assign rsp_final_section_index = fifo_ff[rd_ptr_ff].final_section_index;
   assign rsp_entry_count         = fifo_ff[rd_ptr_ff].entry_count;
   assign rsp_status              = fifo_ff[rd_ptr_ff].status;
   assign rsp_last                = fifo_ff[rd_ptr_ff].last;

endmodule

[hw/rtl/psp_checker.sv]
module psp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [15:0] rsp_prog_num,
   input logic [15:0] rsp_ts_ident,
   input logic [9:0]  rsp_entry_count,
   input logic [3:0]  rsp_status,
   input logic        rsp_last
);
   import psp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prog_num)
                                 && $stable(rsp_kind) && $stable(rsp_status))
      else $error("stalled rsp beat changed");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SUMMARY |-> rsp_last)
      else $error("summary beat without last");

   a_entry_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ENTRY |->
         rsp_status == 4'(ST_OK) && rsp_ts_ident == 16'd0 && rsp_entry_count == 10'd0)
      else $error("entry beat carries summary fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind pat_section_parser psp_checker u_psp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_prog_num       (rsp_prog_num),
   .rsp_ts_ident       (rsp_ts_ident),
   .rsp_entry_count    (rsp_entry_count),
   .rsp_status         (rsp_status),
   .rsp_last           (rsp_last)
);
